// ----- src/mfpa_pkg.sv -----
`default_nettype none

package mfpa_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_PORTS   = 4;   // at most 4: source_port is two bits wide

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PORT_W = 2;
    localparam int ID_W   = 16;
    localparam int PRIO_W = 2;

    // Result codes
    typedef enum logic [1:0] {
        EV_PUSHED  = 2'd0,
        EV_DROPPED = 2'd1,
        EV_GRANTED = 2'd2,
        EV_IDLE    = 2'd3
    } t_event;

    // One queued request
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [PORT_W-1:0] target;
    } t_entry;

    // Circular pointer advance
    function automatic logic [IDX_W-1:0] nxt_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/multi_fifo_priority_arbiter_unit.sv -----
`default_nettype none

// Strict-priority arbiter with one circular FIFO per source port. Every accepted
// item yields exactly one result transfer: a push (mode 0) appends
// {req_id, req_priority, target_port} to the queue of source_port and reports
// pushed, or dropped when that queue already holds QUEUE_DEPTH requests. A grant
// (mode 1) pops the head with the highest priority over all non-empty queues,
// ties going to the lowest port index, and reports it; with every queue empty it
// reports idle. Fields that carry no meaning for a result are zero. Throughput is
// one item per clock while i_stall does not hold the result register; an item
// passes the input register and then the result register, with the queue update
// and the four-way head compare between them. Each queue keeps its head entry in
// a register: a push into an empty queue loads it directly, a pop refills it from
// storage, so all heads are compared in the same cycle. Queue storage is not
// cleared by reset; only the pointers and fill counts are.
module multi_fifo_priority_arbiter_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // item channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_mode,
    input  wire logic [mfpa_pkg::ID_W-1:0]  i_req_id,
    input  wire logic [mfpa_pkg::PRIO_W-1:0] i_req_priority,
    input  wire logic [mfpa_pkg::PORT_W-1:0] i_source_port,
    input  wire logic [mfpa_pkg::PORT_W-1:0] i_target_port,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [1:0]                      o_event_res,
    output logic [mfpa_pkg::ID_W-1:0]       o_out_id,
    output logic [mfpa_pkg::PRIO_W-1:0]     o_out_priority,
    output logic [mfpa_pkg::PORT_W-1:0]     o_out_source,
    output logic [mfpa_pkg::PORT_W-1:0]     o_out_target
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                           r_in_valid;
    logic                           r_mode;
    logic [mfpa_pkg::ID_W-1:0]      r_id;
    logic [mfpa_pkg::PRIO_W-1:0]    r_prio;
    logic [mfpa_pkg::PORT_W-1:0]    r_src;
    logic [mfpa_pkg::PORT_W-1:0]    r_tgt;

    // Result register
    logic                           r_out_valid;
    mfpa_pkg::t_event               r_out_event;
    mfpa_pkg::t_entry               r_out_entry;
    logic [mfpa_pkg::PORT_W-1:0]    r_out_src;

    // Queue control
    logic [mfpa_pkg::IDX_W-1:0]     r_head  [mfpa_pkg::NUM_PORTS];
    logic [mfpa_pkg::IDX_W-1:0]     r_tail  [mfpa_pkg::NUM_PORTS];
    logic [mfpa_pkg::CNT_W-1:0]     r_count [mfpa_pkg::NUM_PORTS];

    mfpa_pkg::t_entry               w_head_entry [mfpa_pkg::NUM_PORTS];

    logic                           out_free;
    logic                           fire;
    logic                           src_full;
    logic                           push_ok;
    logic                           grant_ok;
    logic                           found;
    logic [mfpa_pkg::PORT_W-1:0]    best_port;
    mfpa_pkg::t_entry               best_entry;
    mfpa_pkg::t_entry               push_entry;

    mfpa_pkg::t_event               n_event;
    mfpa_pkg::t_entry               n_entry;
    logic [mfpa_pkg::PORT_W-1:0]    n_src;

    // The result register frees up when empty or when its transfer completes,
    // so a new item moves through every cycle under a flowing output.
    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_mode <= i_mode;
            r_id   <= i_req_id;
            r_prio <= i_req_priority;
            r_src  <= i_source_port;
            r_tgt  <= i_target_port;
        end
    end

    // ------------------------------------------------------------------
    // Per-port queue storage with a registered head entry
    // ------------------------------------------------------------------
    assign push_entry = '{id: r_id, prio: r_prio, target: r_tgt};

    for (genvar gp = 0; gp < mfpa_pkg::NUM_PORTS; gp++) begin : g_port
        mfpa_pkg::t_entry r_mem [mfpa_pkg::QUEUE_DEPTH];
        mfpa_pkg::t_entry r_head_entry;

        always_ff @(posedge i_clk) begin
            if (fire && push_ok && (r_src == mfpa_pkg::PORT_W'(gp))) begin
                r_mem[r_tail[gp]] <= push_entry;
            end
        end

        // push into an empty queue becomes the head at once; a pop pulls the
        // next entry (don't care when the queue goes empty)
        always_ff @(posedge i_clk) begin
            if (fire && push_ok && (r_src == mfpa_pkg::PORT_W'(gp)) &&
                (r_count[gp] == '0)) begin
                r_head_entry <= push_entry;
            end else if (fire && grant_ok && (best_port == mfpa_pkg::PORT_W'(gp))) begin
                r_head_entry <= r_mem[mfpa_pkg::nxt_idx(r_head[gp])];
            end
        end

        assign w_head_entry[gp] = r_head_entry;
    end

    // ------------------------------------------------------------------
    // Push check and head arbitration
    // ------------------------------------------------------------------
    assign src_full = (32'(r_src) >= mfpa_pkg::NUM_PORTS) ||
                      (r_count[r_src] == mfpa_pkg::CNT_W'(mfpa_pkg::QUEUE_DEPTH));
    assign push_ok  = !r_mode && !src_full;

    // Strict greater-than keeps the lowest port on a tie.
    always_comb begin
        found      = 1'b0;
        best_port  = '0;
        best_entry = '0;
        for (int p = 0; p < mfpa_pkg::NUM_PORTS; p++) begin
            if ((r_count[p] != '0) &&
                (!found || (w_head_entry[p].prio > best_entry.prio))) begin
                found      = 1'b1;
                best_port  = mfpa_pkg::PORT_W'(p);
                best_entry = w_head_entry[p];
            end
        end
    end

    assign grant_ok = r_mode && found;

    always_comb begin
        n_entry = '0;
        n_src   = '0;
        if (!r_mode) begin
            n_event = push_ok ? mfpa_pkg::EV_PUSHED : mfpa_pkg::EV_DROPPED;
        end else if (found) begin
            n_event = mfpa_pkg::EV_GRANTED;
            n_entry = best_entry;
            n_src   = best_port;
        end else begin
            n_event = mfpa_pkg::EV_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // Pointer and fill count update (one push or one pop per item)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < mfpa_pkg::NUM_PORTS; p++) begin
                r_head[p]  <= '0;
                r_tail[p]  <= '0;
                r_count[p] <= '0;
            end
        end else if (fire) begin
            if (push_ok) begin
                r_tail[r_src]  <= mfpa_pkg::nxt_idx(r_tail[r_src]);
                r_count[r_src] <= r_count[r_src] + 1'b1;
            end
            if (grant_ok) begin
                r_head[best_port]  <= mfpa_pkg::nxt_idx(r_head[best_port]);
                r_count[best_port] <= r_count[best_port] - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_event <= n_event;
            r_out_entry <= n_entry;
            r_out_src   <= n_src;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_res    = r_out_event;
    assign o_out_id       = r_out_entry.id;
    assign o_out_priority = r_out_entry.prio;
    assign o_out_source   = r_out_src;
    assign o_out_target   = r_out_entry.target;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    for (genvar ga = 0; ga < mfpa_pkg::NUM_PORTS; ga++) begin : g_chk
        // empty or full queue must have coinciding pointers
        a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            ((r_count[ga] == '0) ||
             (r_count[ga] == mfpa_pkg::CNT_W'(mfpa_pkg::QUEUE_DEPTH)))
            |-> (r_head[ga] == r_tail[ga]))
            else $error("queue %0d pointers disagree with fill count", ga);

        a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_count[ga] <= mfpa_pkg::CNT_W'(mfpa_pkg::QUEUE_DEPTH))
            else $error("queue %0d fill count above depth", ga);
    end

    // a grant with anything queued must come out as a grant
    a_grant_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_mode && found) |=> (r_out_valid && (r_out_event == mfpa_pkg::EV_GRANTED)))
        else $error("pending request not granted");

    // a dropped push leaves that queue's fill count untouched
    a_drop_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_mode && src_full && (32'(r_src) < mfpa_pkg::NUM_PORTS))
        |=> ((r_out_event == mfpa_pkg::EV_DROPPED) &&
             (r_count[$past(r_src)] == mfpa_pkg::CNT_W'(mfpa_pkg::QUEUE_DEPTH))))
        else $error("dropped push changed queue state");

endmodule

`default_nettype wire
